FILE: sv/qrs_pkg.sv
package qrs_pkg;

    // default widths
    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;

    // fixed width of each result value
    localparam int OUT_W = 34;

    // root classification carried in tuser
    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_EQUAL    = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_ZERO     = 2'd3
    } root_kind_t;

endpackage

FILE: sv/qrs_disc.sv
module qrs_disc #(
    parameter int CW   = qrs_pkg::COEF_WIDTH,
    parameter int FRAC = qrs_pkg::FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [CW-1:0]     in_a,
    input  logic signed [CW-1:0]     in_b,
    input  logic signed [CW-1:0]     in_c,
    output logic                     out_valid,
    output qrs_pkg::root_kind_t      out_kind,
    output logic [2*CW:0]            out_mag,
    output logic signed [CW+FRAC:0]  out_nb,
    output logic signed [CW-1:0]     out_a
);
    localparam int DW  = 2 * CW + 2;
    localparam int MW  = 2 * CW + 1;
    localparam int NBW = CW + FRAC + 1;

    logic                   v1_reg;
    logic signed [2*CW-1:0] bb_reg;
    logic signed [2*CW-1:0] ac_reg;
    logic signed [CW-1:0]   a1_reg;
    logic signed [CW-1:0]   b1_reg;

    // stage one: the two products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            bb_reg <= in_b * in_b;
            ac_reg <= in_a * in_c;
            a1_reg <= in_a;
            b1_reg <= in_b;
        end
    end

    logic signed [DW-1:0]  disc;
    logic [DW-1:0]         disc_abs;
    logic signed [NBW-1:0] b_ext;
    qrs_pkg::root_kind_t   kind_next;

    // discriminant, its magnitude and the class of the roots
    always_comb begin
        disc     = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
        disc_abs = disc[DW-1] ? DW'(-disc) : DW'(disc);
        b_ext    = NBW'(b1_reg);
        if (a1_reg == '0) begin
            kind_next = qrs_pkg::KIND_ZERO;
        end else if (disc == '0) begin
            kind_next = qrs_pkg::KIND_EQUAL;
        end else if (disc[DW-1]) begin
            kind_next = qrs_pkg::KIND_COMPLEX;
        end else begin
            kind_next = qrs_pkg::KIND_DISTINCT;
        end
    end

    // stage two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= v1_reg;
        end
        if (en) begin
            out_kind <= kind_next;
            out_mag  <= disc_abs[MW-1:0];
            out_nb   <= -(b_ext <<< FRAC);
            out_a    <= a1_reg;
        end
    end

endmodule

FILE: sv/qrs_sqrt.sv
module qrs_sqrt #(
    parameter int CW    = qrs_pkg::COEF_WIDTH,
    parameter int FRAC  = qrs_pkg::FRAC_BITS,
    parameter int TAG_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2*CW:0]        in_mag,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic [CW+FRAC:0]     out_root,
    output logic [TAG_W-1:0]     out_tag
);
    localparam int RW  = CW + FRAC + 1;
    localparam int XW  = 2 * RW;
    localparam int RMW = RW + 3;

    logic             v_reg    [RW];
    logic [RMW-1:0]   rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [XW-1:0]    x_reg    [RW];
    logic [TAG_W-1:0] tag_reg  [RW];

    // one root bit per stage, restoring form
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic             v_in;
        logic [RMW-1:0]   rem_in;
        logic [RW-1:0]    root_in;
        logic [XW-1:0]    x_in;
        logic [TAG_W-1:0] tag_in;
        logic [RMW-1:0]   cat;
        logic [RMW-1:0]   trial;
        logic             take;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = XW'(in_mag) << (2 * FRAC);
            assign tag_in  = in_tag;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign tag_in  = tag_reg[k-1];
        end

        // bring down two radicand bits and try the next root bit
        assign cat   = {rem_in[RMW-3:0], x_in[XW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = (cat >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
            if (en) begin
                rem_reg[k]  <= take ? cat - trial : cat;
                root_reg[k] <= {root_in[RW-2:0], take};
                x_reg[k]    <= x_in << 2;
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_tag   = tag_reg[RW-1];

endmodule

FILE: sv/qrs_div.sv
module qrs_div #(
    parameter int CW    = qrs_pkg::COEF_WIDTH,
    parameter int FRAC  = qrs_pkg::FRAC_BITS,
    parameter int TAG_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [CW+FRAC+2:0] in_num1,
    input  logic signed [CW+FRAC+2:0] in_num2,
    input  logic signed [CW-1:0]      in_a,
    input  logic [TAG_W-1:0]          in_tag,
    output logic                      out_valid,
    output logic [CW+FRAC+3:0]        out_q1,
    output logic [CW+FRAC+3:0]        out_q2,
    output logic                      out_neg1,
    output logic                      out_neg2,
    output logic [TAG_W-1:0]          out_tag
);
    localparam int NW   = CW + FRAC + 2;
    localparam int NUMW = NW + 1;
    localparam int NDW  = NW + 2;
    localparam int DVW  = CW + 2;
    localparam int RMD  = CW + 3;

    // stage a: magnitudes and result signs
    logic             va_reg;
    logic [NW-1:0]    m1_reg, m2_reg;
    logic [CW-1:0]    d_reg;
    logic             na1_reg, na2_reg;
    logic [TAG_W-1:0] taga_reg;
    logic [NUMW-1:0]  abs1, abs2;

    assign abs1 = in_num1[NUMW-1] ? NUMW'(-in_num1) : NUMW'(in_num1);
    assign abs2 = in_num2[NUMW-1] ? NUMW'(-in_num2) : NUMW'(in_num2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
        if (en) begin
            m1_reg   <= abs1[NW-1:0];
            m2_reg   <= abs2[NW-1:0];
            d_reg    <= in_a[CW-1] ? CW'(-in_a) : CW'(in_a);
            na1_reg  <= in_num1[NUMW-1] ^ in_a[CW-1];
            na2_reg  <= in_num2[NUMW-1] ^ in_a[CW-1];
            taga_reg <= in_tag;
        end
    end

    // stage b: dividend 2n + 2|a| and divisor 4|a| for round to nearest
    logic             vb_reg;
    logic [NDW-1:0]   n1_reg, n2_reg;
    logic [DVW-1:0]   dv_reg;
    logic             nb1_reg, nb2_reg;
    logic [TAG_W-1:0] tagb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
        if (en) begin
            n1_reg   <= (NDW'(m1_reg) << 1) + (NDW'(d_reg) << 1);
            n2_reg   <= (NDW'(m2_reg) << 1) + (NDW'(d_reg) << 1);
            dv_reg   <= DVW'(d_reg) << 2;
            nb1_reg  <= na1_reg;
            nb2_reg  <= na2_reg;
            tagb_reg <= taga_reg;
        end
    end

    logic             v_reg   [NDW];
    logic [RMD-1:0]   r1_reg  [NDW];
    logic [RMD-1:0]   r2_reg  [NDW];
    logic [NDW-1:0]   x1_reg  [NDW];
    logic [NDW-1:0]   x2_reg  [NDW];
    logic [NDW-1:0]   q1_reg  [NDW];
    logic [NDW-1:0]   q2_reg  [NDW];
    logic [DVW-1:0]   dvs_reg [NDW];
    logic             s1_reg  [NDW];
    logic             s2_reg  [NDW];
    logic [TAG_W-1:0] tag_reg [NDW];

    // one quotient bit per stage for both lanes, sharing the divisor
    for (genvar k = 0; k < NDW; k++) begin : g_stage
        logic             v_in, s1_in, s2_in;
        logic [RMD-1:0]   r1_in, r2_in, c1, c2, dvx;
        logic [NDW-1:0]   x1_in, x2_in, q1_in, q2_in;
        logic [DVW-1:0]   dv_in;
        logic [TAG_W-1:0] tag_in;
        logic             t1, t2;

        if (k == 0) begin : g_first
            assign v_in   = vb_reg;
            assign r1_in  = '0;
            assign r2_in  = '0;
            assign x1_in  = n1_reg;
            assign x2_in  = n2_reg;
            assign q1_in  = '0;
            assign q2_in  = '0;
            assign dv_in  = dv_reg;
            assign s1_in  = nb1_reg;
            assign s2_in  = nb2_reg;
            assign tag_in = tagb_reg;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign r1_in  = r1_reg[k-1];
            assign r2_in  = r2_reg[k-1];
            assign x1_in  = x1_reg[k-1];
            assign x2_in  = x2_reg[k-1];
            assign q1_in  = q1_reg[k-1];
            assign q2_in  = q2_reg[k-1];
            assign dv_in  = dvs_reg[k-1];
            assign s1_in  = s1_reg[k-1];
            assign s2_in  = s2_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        assign dvx = RMD'(dv_in);
        assign c1  = {r1_in[RMD-2:0], x1_in[NDW-1]};
        assign c2  = {r2_in[RMD-2:0], x2_in[NDW-1]};
        assign t1  = (c1 >= dvx);
        assign t2  = (c2 >= dvx);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
            if (en) begin
                r1_reg[k]  <= t1 ? c1 - dvx : c1;
                r2_reg[k]  <= t2 ? c2 - dvx : c2;
                x1_reg[k]  <= x1_in << 1;
                x2_reg[k]  <= x2_in << 1;
                q1_reg[k]  <= {q1_in[NDW-2:0], t1};
                q2_reg[k]  <= {q2_in[NDW-2:0], t2};
                dvs_reg[k] <= dv_in;
                s1_reg[k]  <= s1_in;
                s2_reg[k]  <= s2_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[NDW-1];
    assign out_q1    = q1_reg[NDW-1];
    assign out_q2    = q2_reg[NDW-1];
    assign out_neg1  = s1_reg[NDW-1];
    assign out_neg2  = s2_reg[NDW-1];
    assign out_tag   = tag_reg[NDW-1];

endmodule

FILE: sv/quadratic_root_solver_top.sv
// Quadratic root solver: takes one coefficient set (a, b, c) per item and
// returns one result item: the root class in m_tuser and two signed values
// with FRAC_BITS fraction bits in m_tdata. A new item is taken every clock
// cycle unless the output stalls. Items pass in order through the products
// and the discriminant, the square root pipeline, the numerators, the
// magnitudes and rounding offset, the two-lane divider, and sign and
// saturation into the output register. The whole pipeline advances only
// when the output register is empty or being taken, so a stall on m_tready
// holds every item in place and drops s_tready.
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // coef_a, coef_b, coef_c from bit 0 up, zero padded to bytes
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // first_value, second_value from bit 0 up, zero padded to bytes
    output logic [((2*qrs_pkg::OUT_W+7)/8)*8-1:0]   m_tdata,
    // root_kind
    output logic [1:0]                              m_tuser
);
    localparam int CW    = COEF_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int OW    = qrs_pkg::OUT_W;
    localparam int MW    = 2 * CW + 1;
    localparam int RW    = CW + F + 1;
    localparam int NBW   = CW + F + 1;
    localparam int NUMW  = CW + F + 3;
    localparam int NDW   = CW + F + 4;
    localparam int EW    = (NDW > OW + 1) ? NDW : OW + 1;
    localparam int TAG_W = 2 + NBW + CW;
    localparam int MTW   = ((2 * OW + 7) / 8) * 8;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // discriminant and classification
    logic                d_valid;
    qrs_pkg::root_kind_t d_kind;
    logic [MW-1:0]       d_mag;
    logic signed [NBW-1:0] d_nb;
    logic signed [CW-1:0]  d_a;

    qrs_disc #(.CW(CW), .FRAC(F)) u_disc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_a     (s_tdata[CW-1:0]),
        .in_b     (s_tdata[2*CW-1:CW]),
        .in_c     (s_tdata[3*CW-1:2*CW]),
        .out_valid(d_valid),
        .out_kind (d_kind),
        .out_mag  (d_mag),
        .out_nb   (d_nb),
        .out_a    (d_a)
    );

    // scaled square root
    logic             q_valid;
    logic [RW-1:0]    q_root;
    logic [TAG_W-1:0] q_tag;

    qrs_sqrt #(.CW(CW), .FRAC(F), .TAG_W(TAG_W)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (d_valid),
        .in_mag   (d_mag),
        .in_tag   ({d_kind, d_nb, d_a}),
        .out_valid(q_valid),
        .out_root (q_root),
        .out_tag  (q_tag)
    );

    // numerators for the two quotients
    qrs_pkg::root_kind_t   q_kind;
    logic signed [NBW-1:0] q_nb;
    logic signed [CW-1:0]  q_a;
    logic signed [NUMW-1:0] nbx, sx, num1_next, num2_next;

    assign q_kind = qrs_pkg::root_kind_t'(q_tag[TAG_W-1 -: 2]);
    assign q_nb   = q_tag[CW +: NBW];
    assign q_a    = q_tag[CW-1:0];
    assign nbx    = NUMW'(q_nb);
    assign sx     = $signed(NUMW'(q_root));

    always_comb begin
        case (q_kind)
            qrs_pkg::KIND_DISTINCT: begin
                num1_next = nbx + sx;
                num2_next = nbx - sx;
            end
            qrs_pkg::KIND_COMPLEX: begin
                num1_next = nbx;
                num2_next = sx;
            end
            default: begin
                num1_next = nbx;
                num2_next = nbx;
            end
        endcase
    end

    logic                   n_valid_reg;
    logic signed [NUMW-1:0] n1_reg, n2_reg;
    logic signed [CW-1:0]   na_reg;
    logic [1:0]             nk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (en) begin
            n_valid_reg <= q_valid;
        end
        if (en) begin
            n1_reg <= num1_next;
            n2_reg <= num2_next;
            na_reg <= q_a;
            nk_reg <= q_kind;
        end
    end

    // rounded division by 2a
    logic           v_valid;
    logic [NDW-1:0] v_q1, v_q2;
    logic           v_neg1, v_neg2;
    logic [1:0]     v_kind;

    qrs_div #(.CW(CW), .FRAC(F), .TAG_W(2)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (n_valid_reg),
        .in_num1  (n1_reg),
        .in_num2  (n2_reg),
        .in_a     (na_reg),
        .in_tag   (nk_reg),
        .out_valid(v_valid),
        .out_q1   (v_q1),
        .out_q2   (v_q2),
        .out_neg1 (v_neg1),
        .out_neg2 (v_neg2),
        .out_tag  (v_kind)
    );

    // sign and saturation to the output range
    localparam logic [EW-1:0] POS_MAX = (EW'(1) << (OW - 1)) - EW'(1);
    localparam logic [EW-1:0] NEG_MAG = EW'(1) << (OW - 1);

    logic [EW-1:0] e1, e2;
    logic [OW-1:0] r1_next, r2_next;

    assign e1 = EW'(v_q1);
    assign e2 = EW'(v_q2);

    always_comb begin
        if (v_neg1) begin
            r1_next = (e1 > NEG_MAG) ? NEG_MAG[OW-1:0] : OW'(-e1);
        end else begin
            r1_next = (e1 > POS_MAX) ? POS_MAX[OW-1:0] : e1[OW-1:0];
        end
        if (v_neg2) begin
            r2_next = (e2 > NEG_MAG) ? NEG_MAG[OW-1:0] : OW'(-e2);
        end else begin
            r2_next = (e2 > POS_MAX) ? POS_MAX[OW-1:0] : e2[OW-1:0];
        end
        if (v_kind == qrs_pkg::KIND_ZERO) begin
            r1_next = '0;
            r2_next = '0;
        end
    end

    // output register
    logic [OW-1:0] first_reg, second_reg;
    logic [1:0]    kind_reg;
    logic          m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_valid;
        end
        if (en) begin
            first_reg  <= r1_next;
            second_reg <= r2_next;
            kind_reg   <= v_kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = MTW'({second_reg, first_reg});

    // checks
    a_zero_values : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == qrs_pkg::KIND_ZERO |-> m_tdata == '0)
        else $error("leading coefficient zero with nonzero values");

    a_equal_roots : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == qrs_pkg::KIND_EQUAL |-> first_reg == second_reg)
        else $error("equal roots differ");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CW       = qrs_pkg::COEF_WIDTH;
    localparam int FB       = qrs_pkg::FRAC_BITS;
    localparam int OUT_W    = qrs_pkg::OUT_W;
    localparam int SDW      = ((3*CW+7)/8)*8;
    localparam int MDW      = ((2*OUT_W+7)/8)*8;
    localparam int LATENCY  = 2 + (CW+FB+1) + 3 + (CW+FB+4) + 1;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        qrs_pkg::root_kind_t     kind;
        logic signed [OUT_W-1:0] first;
        logic signed [OUT_W-1:0] second;
    } roots_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [SDW-1:0]  s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [MDW-1:0]  m_tdata;
    logic [1:0]      m_tuser;

    roots_t          roots_q[$];
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_cycles = 0;
    int              errors = 0;
    int              items_sent = 0;
    int              results_seen = 0;
    int              kind_count[4];
    longint          cycles = 0;

    quadratic_root_solver_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // floor(sqrt(d * 2^(2*FB)))
    function automatic logic [127:0] root_scaled(input logic [127:0] d);
        logic [127:0] x;
        logic [127:0] r;
        logic [127:0] c;
        x = d << (2*FB);
        r = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            c = r | (128'd1 << bit_i);
            if (c * c <= x)
                r = c;
        end
        return r;
    endfunction

    // round to nearest, ties away from zero, saturated to the value width
    function automatic logic signed [OUT_W-1:0] div_round(input longint num,
                                                          input longint den);
        logic         neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = (2*n + d) / (2*d);
        if (neg) begin
            if (q > (128'd1 << (OUT_W-1)))
                return {1'b1, {(OUT_W-1){1'b0}}};
            return -$signed(q[OUT_W-1:0]);
        end
        if (q > (128'd1 << (OUT_W-1)) - 1)
            return {1'b0, {(OUT_W-1){1'b1}}};
        return q[OUT_W-1:0];
    endfunction

    // expected roots for one coefficient set
    function automatic roots_t solve_roots(input logic signed [CW-1:0] a,
                                           input logic signed [CW-1:0] b,
                                           input logic signed [CW-1:0] c);
        roots_t       r;
        longint       disc;
        longint       den;
        longint       nb;
        longint       s;
        r = '0;
        if (a == 0) begin
            r.kind = qrs_pkg::KIND_ZERO;
            return r;
        end
        disc = longint'(b) * b - 4 * longint'(a) * c;
        den  = 2 * longint'(a);
        nb   = -longint'(b) * (longint'(1) << FB);
        s    = longint'(root_scaled(disc < 0 ? -disc : disc));
        if (disc > 0) begin
            r.kind   = qrs_pkg::KIND_DISTINCT;
            r.first  = div_round(nb + s, den);
            r.second = div_round(nb - s, den);
        end else if (disc == 0) begin
            r.kind   = qrs_pkg::KIND_EQUAL;
            r.first  = div_round(nb, den);
            r.second = r.first;
        end else begin
            r.kind   = qrs_pkg::KIND_COMPLEX;
            r.first  = div_round(nb, den);
            r.second = div_round(s, den);
        end
        return r;
    endfunction

    // send one coefficient item and queue its expected roots
    task automatic send_coefs(input logic [CW-1:0] a, input logic [CW-1:0] b,
                              input logic [CW-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= SDW'({c, b, a});
        do @(posedge aclk); while (!s_tready);
        roots_q.push_back(solve_roots(a, b, c));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (roots_q.size() != 0)
            @(negedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(5))
            0: return CW'($urandom_range(15)) - CW'(8);
            1: return {1'b1, {(CW-1){1'b0}}} + CW'($urandom_range(3));
            2: return {1'b0, {(CW-1){1'b1}}} - CW'($urandom_range(3));
            default: return CW'($urandom);
        endcase
    endfunction

    // receiver ready, with random idling and an optional long hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        roots_t exp_r;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (roots_q.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                exp_r = roots_q.pop_front();
                kind_count[exp_r.kind]++;
                if (m_tuser !== exp_r.kind) begin
                    $error("root_kind exp %0d got %0d", exp_r.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[OUT_W-1:0] !== exp_r.first) begin
                    $error("first_value exp %0d got %0d", exp_r.first,
                           $signed(m_tdata[OUT_W-1:0]));
                    errors++;
                end
                if (m_tdata[2*OUT_W-1:OUT_W] !== exp_r.second) begin
                    $error("second_value exp %0d got %0d", exp_r.second,
                           $signed(m_tdata[2*OUT_W-1:OUT_W]));
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // extremes, each root class and the zero leading coefficient
    task automatic test_directed();
        logic [CW-1:0] mx;
        logic [CW-1:0] mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        send_coefs(CW'(1), CW'(-3), CW'(2));
        send_coefs(CW'(1), CW'(2), CW'(1));
        send_coefs(CW'(1), CW'(0), CW'(1));
        send_coefs(CW'(-1), CW'(0), CW'(1));
        send_coefs(CW'(-2), CW'(4), CW'(-2));
        send_coefs(CW'(0), CW'(5), CW'(7));
        send_coefs(CW'(0), mn, mx);
        send_coefs(mx, mx, mx);
        send_coefs(mn, mn, mn);
        send_coefs(mx, mn, mn);
        send_coefs(mn, mx, mx);
        send_coefs(CW'(1), mn, mn);
        send_coefs(CW'(1), mx, mn);
        send_coefs(CW'(-1), mn, mx);
        send_coefs(mn, CW'(0), mx);
        send_coefs(mx, CW'(0), mn);
        send_coefs(CW'(1), CW'(0), CW'(0));
        send_coefs(CW'(2), CW'(1), CW'(0));
        send_coefs(CW'(2), CW'(2), CW'(1));
        send_coefs(CW'(-3), CW'(1), CW'(-1));
        send_coefs('1, '1, '1);
        wait_drained();
    endtask

    // random coefficient sets
    task automatic test_random(input int n);
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] c;
        int            k;
        for (int i = 0; i < n; i++) begin
            a = rand_coef();
            b = rand_coef();
            c = rand_coef();
            if ($urandom_range(9) == 0)
                a = '0;
            // build a perfect square now and then: b = 2*k*a', c = k*k*a'
            if ($urandom_range(7) == 0) begin
                k = $urandom_range(20) - 10;
                a = CW'($urandom_range(40) - 20);
                if (a == 0) a = CW'(1);
                b = CW'(2 * k * $signed(a));
                c = CW'(k * k * $signed(a));
            end
            send_coefs(a, b, c);
        end
        wait_drained();
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge aclk);
        hold_cycles = 3 * LATENCY;
        test_random(150);
    endtask

    initial begin
        kind_count = '{default: 0};
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 10; recv_idle_pct = 64;
        test_directed();
        test_random(450);
        send_idle_pct = 64; recv_idle_pct = 10;
        test_random(450);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(450);
        test_backpressure();

        $display("sent %0d coefficient items, checked %0d results", items_sent,
                 results_seen);
        $display("distinct %0d, equal %0d, complex %0d, zero a %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        if (errors == 0 && roots_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/qrs_pkg.sv
sv/qrs_disc.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver_top.sv
sim/tb.sv
